### sv/acc_alu_pkg.sv
// ----------------------------------------------------------------------------
// acc_alu_pkg
// Shared types, opcode constants and the opcode decoder for the
// accumulator ALU with stack.
// ----------------------------------------------------------------------------
package acc_alu_pkg;

  // Instruction codes
  localparam logic [7:0] OPC_MOV  = 8'hB8;
  localparam logic [7:0] OPC_ADD  = 8'h01;
  localparam logic [7:0] OPC_SUB  = 8'h29;
  localparam logic [7:0] OPC_MUL  = 8'hF7;
  localparam logic [7:0] OPC_XOR  = 8'h31;
  localparam logic [7:0] OPC_AND  = 8'h21;
  localparam logic [7:0] OPC_OR   = 8'h09;
  localparam logic [7:0] OPC_SHL  = 8'hD1;
  localparam logic [7:0] OPC_SHR  = 8'hD3;
  localparam logic [7:0] OPC_CMP  = 8'h39;
  localparam logic [7:0] OPC_PUSH = 8'h50;
  localparam logic [7:0] OPC_POP  = 8'h58;

  // Flag word returned by a compare that finds the operands equal
  localparam logic [63:0] ZERO_WORD = 64'h40;

  // Decoded operation class carried down the pipeline
  typedef enum logic [3:0] {
    OP_NONE,
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_XOR,
    OP_AND,
    OP_OR,
    OP_SHL,
    OP_SHR,
    OP_CMP,
    OP_PUSH,
    OP_POP
  } op_cls_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic        result_written;
    logic [63:0] result_value;
  } out_item_t;

  // Per-stage load controls from the pipeline handshake
  typedef struct packed {
    logic ld_s2;   // stage 1 item moves into stage 2
    logic ld_out;  // stage 2 item moves into the result register
  } pipe_ctl_t;

  function automatic op_cls_t decode_op(input logic [7:0] opc);
    op_cls_t cls;
    unique case (opc)
      OPC_MOV:  cls = OP_MOV;
      OPC_ADD:  cls = OP_ADD;
      OPC_SUB:  cls = OP_SUB;
      OPC_MUL:  cls = OP_MUL;
      OPC_XOR:  cls = OP_XOR;
      OPC_AND:  cls = OP_AND;
      OPC_OR:   cls = OP_OR;
      OPC_SHL:  cls = OP_SHL;
      OPC_SHR:  cls = OP_SHR;
      OPC_CMP:  cls = OP_CMP;
      OPC_PUSH: cls = OP_PUSH;
      OPC_POP:  cls = OP_POP;
      default:  cls = OP_NONE;
    endcase
    return cls;
  endfunction

endpackage

### sv/accumulator_alu_with_stack_unit.sv
// ----------------------------------------------------------------------------
// accumulator_alu_with_stack_unit
// The accepted item passes through the input register, then the execute
//   register, then the result register, where out_valid rises.
// Throughput: one item per cycle unless out_stall holds the pipeline; the
//   64x64 multiply is split over the first two stages as 32-bit partial products.
// Reset clears the pipeline, the accumulator and the stack pointer; the
//   stack store itself is not cleared.
// ----------------------------------------------------------------------------
module accumulator_alu_with_stack_unit
  import acc_alu_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic        v1_r, v2_r, ov_r;
  op_cls_t     cls1_r;
  logic [63:0] a1_r, b1_r;
  logic        adv1, adv2, adv3;
  logic        accept;
  op_cls_t     in_cls;
  pipe_ctl_t   ctl;

  logic [DW-1:0] stk_depth;
  logic          stk_pop_ok;
  logic [63:0]   stk_pop_data;

  // Stage enables: a stage can load when it is empty or its item is moving on
  assign adv3     = !ov_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;
  assign accept   = in_valid && adv1;
  assign in_cls   = decode_op(in_data.opcode);

  assign ctl.ld_s2  = v1_r && adv2;
  assign ctl.ld_out = v2_r && adv3;

  // Hold the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        ov_r <= v2_r;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      cls1_r <= in_cls;
      a1_r   <= in_data.operand_a;
      b1_r   <= in_data.operand_b;
    end
  end

  acc_alu_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cls       (in_cls),
    .push_data (in_data.operand_a),
    .depth     (stk_depth),
    .pop_ok    (stk_pop_ok),
    .pop_data  (stk_pop_data)
  );

  acc_alu_exec #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .s1_cls      (cls1_r),
    .s1_a        (a1_r),
    .s1_b        (b1_r),
    .s1_depth    (stk_depth),
    .s1_pop_ok   (stk_pop_ok),
    .s1_pop_data (stk_pop_data),
    .out_item    (out_data)
  );

  assign out_valid = ov_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && ov_r && out_stall)
    else $error("input stalled with a free stage");

  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(v2_r))
    else $error("result appeared without an item in stage 2");

endmodule

### sv/acc_alu_ram.sv
// ----------------------------------------------------------------------------
// acc_alu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acc_alu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/acc_alu_stack.sv
// ----------------------------------------------------------------------------
// acc_alu_stack
// Stack pointer and stack store. Push and pop are resolved when the item
// is accepted; the popped word and the depth are registered and appear in the cycle after acceptance.
// ----------------------------------------------------------------------------
module acc_alu_stack
  import acc_alu_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  op_cls_t                          cls,
  input  logic [63:0]                      push_data,
  output logic [$clog2(STACK_DEPTH+1)-1:0] depth,
  output logic                             pop_ok,
  output logic [63:0]                      pop_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] depth_dec;
  logic          pop_ok_r, pop_ok_nxt;
  logic          full, empty;
  logic          wr_en, rd_en;

  assign full      = (depth_r == DW'(STACK_DEPTH));
  assign empty     = (depth_r == '0);
  assign depth_dec = depth_r - DW'(1);
  assign wr_en     = accept && (cls == OP_PUSH) && !full;
  assign rd_en     = accept && (cls == OP_POP) && !empty;

  // Advance the stack pointer
  always_comb begin
    depth_nxt  = depth_r;
    pop_ok_nxt = pop_ok_r;
    if (accept) begin
      pop_ok_nxt = rd_en;
      if (wr_en) begin
        depth_nxt = depth_r + DW'(1);
      end else if (rd_en) begin
        depth_nxt = depth_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= '0;
      pop_ok_r <= 1'b0;
    end else begin
      depth_r  <= depth_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
  end

  acc_alu_ram #(
    .WIDTH(64),
    .DEPTH(STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (depth_r[AW-1:0]),
    .wr_data (push_data),
    .rd_en   (rd_en),
    .rd_addr (depth_dec[AW-1:0]),
    .rd_data (pop_data)
  );

  assign depth  = depth_r;
  assign pop_ok = pop_ok_r;

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> depth_r == $past(depth_r) + DW'(1))
    else $error("push did not advance the stack pointer");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("stack read and write in one cycle");

endmodule

### sv/acc_alu_exec.sv
// ----------------------------------------------------------------------------
// acc_alu_exec
// Execute datapath: stage 1 computes moves, logic, adds, subtracts, shifts,
// compares and the 32-bit partial products; stage 2 completes the multiply,
// resolves pops and updates the accumulator; then the result register.
// ----------------------------------------------------------------------------
module acc_alu_exec
  import acc_alu_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pipe_ctl_t                        ctl,
  input  op_cls_t                          s1_cls,
  input  logic [63:0]                      s1_a,
  input  logic [63:0]                      s1_b,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] s1_depth,
  input  logic                             s1_pop_ok,
  input  logic [63:0]                      s1_pop_data,
  output out_item_t                        out_item
);

  // Stage 1 results
  logic [63:0] val_s1;
  logic [63:0] pp_ll_s1;
  logic [31:0] pp_lh_s1, pp_hl_s1;

  // Stage 2 registers
  op_cls_t     cls_r;
  logic [63:0] val_r;
  logic [63:0] pp_ll_r;
  logic [31:0] pp_lh_r, pp_hl_r;
  logic        pop_ok_r;
  logic [63:0] pop_data_r;

  // Architectural accumulator and result register
  logic [63:0] acc_r, acc_nxt;
  out_item_t   out_r;

  logic [31:0] cross_s2;
  logic [63:0] mul_s2;
  logic [63:0] res_s2;
  logic        acc_we;

  // Compute every non-multiply, non-pop value in stage 1
  always_comb begin
    case (s1_cls)
      OP_MOV:  val_s1 = s1_a;
      OP_ADD:  val_s1 = s1_a + s1_b;
      OP_SUB:  val_s1 = s1_a - s1_b;
      OP_XOR:  val_s1 = s1_a ^ s1_b;
      OP_AND:  val_s1 = s1_a & s1_b;
      OP_OR:   val_s1 = s1_a | s1_b;
      OP_SHL:  val_s1 = s1_a << s1_b[5:0];
      OP_SHR:  val_s1 = s1_a >> s1_b[5:0];
      OP_CMP:  val_s1 = (s1_a == s1_b) ? ZERO_WORD : 64'd0;
      OP_PUSH: val_s1 = 64'(s1_depth);
      default: val_s1 = 64'd0;
    endcase
  end

  // Partial products: only the low halves of the cross terms matter
  assign pp_ll_s1 = 64'(s1_a[31:0]) * 64'(s1_b[31:0]);
  assign pp_lh_s1 = s1_a[31:0] * s1_b[63:32];
  assign pp_hl_s1 = s1_a[63:32] * s1_b[31:0];

  always_ff @(posedge clk) begin
    if (ctl.ld_s2) begin
      cls_r      <= s1_cls;
      val_r      <= val_s1;
      pp_ll_r    <= pp_ll_s1;
      pp_lh_r    <= pp_lh_s1;
      pp_hl_r    <= pp_hl_s1;
      pop_ok_r   <= s1_pop_ok;
      pop_data_r <= s1_pop_data;
    end
  end

  // Finish the multiply and pick the result in stage 2
  assign cross_s2 = pp_lh_r + pp_hl_r;
  assign mul_s2   = pp_ll_r + {cross_s2, 32'd0};

  always_comb begin
    case (cls_r)
      OP_MUL:  res_s2 = mul_s2;
      OP_POP:  res_s2 = pop_ok_r ? pop_data_r : acc_r;
      default: res_s2 = val_r;
    endcase
  end

  always_comb begin
    case (cls_r) inside
      OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_XOR, OP_AND, OP_OR, OP_SHL, OP_SHR:
        acc_we = 1'b1;
      OP_POP:
        acc_we = pop_ok_r;
      default:
        acc_we = 1'b0;
    endcase
  end

  assign acc_nxt = (ctl.ld_out && acc_we) ? res_s2 : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_r.result_written <= (cls_r != OP_NONE);
      out_r.result_value   <= res_s2;
    end
  end

  assign out_item = out_r;

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.ld_out |=> acc_r == $past(acc_r))
    else $error("accumulator changed without a committed item");

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out && cls_r == OP_NONE |=> out_r.result_value == 64'd0)
    else $error("unwritten result carries a value");

  a_cmp_word: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ld_out && cls_r == OP_CMP
      |=> out_r.result_value == ZERO_WORD || out_r.result_value == 64'd0)
    else $error("compare result is not a flag word");

endmodule
